// File: hw/rtl/gwm_pkg.sv
package gwm_pkg;

  // Default geometry of the matcher.
  localparam int PATTERN_MAX_DEF = 32;
  localparam int CHAR_BITS_DEF   = 16;

  // Packed stream widths, rounded up to whole bytes.
  localparam int CMD_W      = 2;
  localparam int CODE_W     = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // Wildcard character codes.
  localparam logic [31:0] CODE_STAR     = 32'h0000_002A;
  localparam logic [31:0] CODE_QUESTION = 32'h0000_003F;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

endpackage

// File: hw/rtl/glob_wildcard_matcher_unit.sv
// Channel   Direction  Ports                         Contents
// s_axis    in         s_tvalid/s_tready/s_tdata     command, pattern or text character
//                      s_tlast                       last character of a text
// m_axis    out        m_tvalid/m_tready/m_tdata     match verdict and overflow flag
//
// Each accepted transfer is held in the input register and evaluated there; an
// item that produces a result then loads the output register, which drives
// m_tvalid. One item can be accepted every cycle unless a result item waits on a
// stalled output register. The live-position update is one wide add over
// PATTERN_MAX+1 bits that closes the set over runs of stars.
// Reset (rst, synchronous) empties the pattern and drops any text in progress.
// A stalled output register holds the input register only for items that
// produce a result; all other commands keep flowing.
module glob_wildcard_matcher_unit #(
  parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF,
  parameter int CHAR_BITS   = gwm_pkg::CHAR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [1:0] command, [17:2] char_code, [23:18] zero
  input  logic [gwm_pkg::IN_DATA_W-1:0]  s_tdata,
  // last_of_text
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] matched, [1] pattern_overflow, [7:2] zero
  output logic [gwm_pkg::OUT_DATA_W-1:0] m_tdata
);

  // One bit per pattern position plus one for "whole pattern consumed".
  localparam int W = PATTERN_MAX + 1;

  // Input register.
  logic                 in_vld;
  gwm_pkg::cmd_t        in_cmd;
  logic [CHAR_BITS-1:0] in_code;
  logic                 in_last;

  // Pattern state. Bit PATTERN_MAX of the masks is always zero; end_oh marks
  // the position one past the last stored character. start_set is the live set
  // before the first text character: position zero and every position that the
  // leading run of stars reaches. It grows as stars are appended.
  logic [CHAR_BITS-1:0] store [PATTERN_MAX];
  logic [W-1:0]         star_v;
  logic [W-1:0]         ques_v;
  logic [W-1:0]         filled_v;
  logic [W-1:0]         end_oh;
  logic [W-1:0]         start_set;
  logic                 overflow_seen;

  // Text state.
  logic [W-1:0]         live;
  logic                 inside_text;

  // Output register.
  logic                 out_vld;
  logic                 out_match;
  logic                 out_ovf;

  logic [31:0]          code_wide;
  logic [W-1:0]         eq_v;
  logic [W-1:0]         cur_set;
  logic [W-1:0]         keep_set;
  logic [W-1:0]         step_set;
  logic [W-1:0]         next_set;
  logic [W-1:0]         final_set;
  logic                 has_result;
  logic                 out_free;
  logic                 advance;
  logic                 is_star;
  logic                 is_ques;

  // Any position reached through a contiguous run of stars from a live star
  // becomes live. This is a carry chain: live stars generate, stars that are
  // not yet live propagate.
  function automatic logic [W-1:0] close_stars(input logic [W-1:0] s,
                                               input logic [W-1:0] stars);
    logic [W-1:0] gen;
    logic [W-1:0] carries;
    gen     = s & stars;
    carries = (stars + gen) ^ stars ^ gen;
    return s | carries;
  endfunction

  // Character codes are compared in their low CHAR_BITS bits.
  assign code_wide = {16'd0, s_tdata[gwm_pkg::CODE_W+gwm_pkg::CMD_W-1:gwm_pkg::CMD_W]};

  always_comb begin
    eq_v = '0;
    for (int p = 0; p < PATTERN_MAX; p++) begin
      eq_v[p] = (store[p] == in_code);
    end
  end

  assign cur_set   = inside_text ? live : start_set;
  assign keep_set  = cur_set & star_v;
  assign step_set  = cur_set & filled_v & ~star_v & (ques_v | eq_v);
  assign next_set  = close_stars(keep_set | {step_set[W-2:0], 1'b0}, star_v);
  assign final_set = (in_cmd == gwm_pkg::CMD_QUERY) ? start_set : next_set;

  assign is_star = (in_code == gwm_pkg::CODE_STAR[CHAR_BITS-1:0]);
  assign is_ques = (in_code == gwm_pkg::CODE_QUESTION[CHAR_BITS-1:0]);

  // Only the last text character and the empty-text query produce a result,
  // and only those need room in the output register.
  assign has_result = ((in_cmd == gwm_pkg::CMD_TEXT) && in_last) ||
                      (in_cmd == gwm_pkg::CMD_QUERY);
  assign out_free   = !out_vld || m_tready;
  assign advance    = in_vld && (!has_result || out_free);
  assign s_tready   = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= gwm_pkg::cmd_t'(s_tdata[gwm_pkg::CMD_W-1:0]);
      in_code <= code_wide[CHAR_BITS-1:0];
      in_last <= s_tlast;
    end
  end

  // Pattern storage; each entry is written only when it is the next free slot.
  always_ff @(posedge clk) begin
    for (int p = 0; p < PATTERN_MAX; p++) begin
      if (advance && (in_cmd == gwm_pkg::CMD_APPEND) && end_oh[p]) begin
        store[p] <= in_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      star_v        <= '0;
      ques_v        <= '0;
      filled_v      <= '0;
      end_oh        <= W'(1);
      start_set     <= W'(1);
      overflow_seen <= 1'b0;
      live          <= '0;
      inside_text   <= 1'b0;
    end else if (advance) begin
      unique case (in_cmd)
        gwm_pkg::CMD_CLEAR: begin
          star_v        <= '0;
          ques_v        <= '0;
          filled_v      <= '0;
          end_oh        <= W'(1);
          start_set     <= W'(1);
          overflow_seen <= 1'b0;
          live          <= '0;
          inside_text   <= 1'b0;
        end
        gwm_pkg::CMD_APPEND: begin
          if (end_oh[PATTERN_MAX]) begin
            overflow_seen <= 1'b1;
          end else begin
            star_v    <= star_v | (end_oh & {W{is_star}});
            ques_v    <= ques_v | (end_oh & {W{is_ques}});
            filled_v  <= filled_v | end_oh;
            end_oh    <= {end_oh[W-2:0], 1'b0};
            // A star that extends the leading run of stars opens the next position.
            start_set <= start_set | ({end_oh[W-2:0], 1'b0} &
                                      {W{is_star && |(start_set & end_oh)}});
          end
          live        <= '0;
          inside_text <= 1'b0;
        end
        gwm_pkg::CMD_TEXT: begin
          live        <= in_last ? '0 : next_set;
          inside_text <= !in_last;
        end
        gwm_pkg::CMD_QUERY: begin
          live        <= '0;
          inside_text <= 1'b0;
        end
        default: begin
          live        <= '0;
          inside_text <= 1'b0;
        end
      endcase
    end
  end

  // Output register: loads when a result-producing item advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance && has_result) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_match <= !overflow_seen && |(final_set & end_oh);
      out_ovf   <= overflow_seen;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {{(gwm_pkg::OUT_DATA_W-2){1'b0}}, out_ovf, out_match};

endmodule

// File: hw/rtl/gwm_checker.sv
module gwm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [gwm_pkg::OUT_DATA_W-1:0] m_tdata
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // An overflowed pattern never reports a match.
  a_ovf_nomatch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> !m_tdata[0])
    else $error("match reported with pattern overflow");

  // The input only stalls behind a full output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // A ready output side never stalls the input.
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled although output is ready");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind glob_wildcard_matcher_unit gwm_checker u_gwm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int PAT_MAX     = gwm_pkg::PATTERN_MAX_DEF;
  localparam int CW          = gwm_pkg::CODE_W;
  localparam int STALL_LIMIT = 2000;  // cycles without any transfer
  localparam int DRAIN_WAIT  = 12;
  localparam int HOLD_CYCLES = 300;

  localparam logic [CW-1:0] STAR  = gwm_pkg::CODE_STAR[CW-1:0];
  localparam logic [CW-1:0] QMARK = gwm_pkg::CODE_QUESTION[CW-1:0];

  localparam logic [PAT_MAX:0] START_BIT = {{PAT_MAX{1'b0}}, 1'b1};

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [gwm_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                           s_tlast;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [gwm_pkg::OUT_DATA_W-1:0] m_tdata;

  // Idle percentages of the current phase, and a request for a long output stall.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_request;
  int unsigned transfers_sent;
  int unsigned fail_count;
  int unsigned stall_cycles;

  // Predictor state.
  logic [CW-1:0]     pat_chars [PAT_MAX];
  int unsigned       pat_len;
  logic [PAT_MAX:0]  live_set;
  logic              in_text;
  logic              pat_overflow;
  verdict_t          pending_verdicts [$];

  glob_wildcard_matcher_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [1:0] command, [17:2] char_code, [23:18] zero
    .s_tlast  (s_tlast),   // last_of_text
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [0] matched, [1] pattern_overflow, [7:2] zero
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A star may match nothing, so every live star also makes the position after it live.
  // Walking upward lets a run of stars pass liveness along in one sweep.
  function automatic logic [PAT_MAX:0] close_over_stars(logic [PAT_MAX:0] set);
    for (int p = 0; p < PAT_MAX; p++) begin
      if (p < pat_len && set[p] && pat_chars[p] == STAR) set[p+1] = 1'b1;
    end
    return set;
  endfunction

  // One text character: a star keeps its own position alive. A question mark or
  // an equal code moves its position on by one. Any other code kills the position.
  function automatic logic [PAT_MAX:0] consume_char(logic [PAT_MAX:0] set,
                                                     logic [CW-1:0] code);
    logic [PAT_MAX:0] next;
    next = '0;
    for (int p = 0; p < PAT_MAX; p++) begin
      if (p < pat_len && set[p]) begin
        if (pat_chars[p] == STAR) next[p] = 1'b1;
        else if (pat_chars[p] == QMARK || pat_chars[p] == code) next[p+1] = 1'b1;
      end
    end
    return close_over_stars(next);
  endfunction

  function automatic void queue_verdict(logic [PAT_MAX:0] set);
    verdict_t v;
    v.matched  = pat_overflow ? 1'b0 : set[pat_len];
    v.overflow = pat_overflow;
    pending_verdicts.push_back(v);
  endfunction

  function automatic void predict_transfer(gwm_pkg::cmd_t cmd, logic [CW-1:0] code,
                                           logic last);
    case (cmd)
      gwm_pkg::CMD_CLEAR: begin
        pat_len      = 0;
        pat_overflow = 1'b0;
        in_text      = 1'b0;
        live_set     = '0;
      end
      gwm_pkg::CMD_APPEND: begin
        // A full pattern refuses the character and remembers the refusal.
        if (pat_len < PAT_MAX) begin
          pat_chars[pat_len] = code;
          pat_len++;
        end else begin
          pat_overflow = 1'b1;
        end
        in_text  = 1'b0;
        live_set = '0;
      end
      gwm_pkg::CMD_TEXT: begin
        if (!in_text) live_set = close_over_stars(START_BIT);
        live_set = consume_char(live_set, code);
        if (!last) begin
          in_text = 1'b1;
        end else begin
          in_text = 1'b0;
          queue_verdict(live_set);
          live_set = '0;
        end
      end
      default: begin
        // An empty-text query also drops any text in progress.
        in_text  = 1'b0;
        live_set = '0;
        queue_verdict(close_over_stars(START_BIT));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // The task is entered and left at a falling edge. Idle cycles come first. Then the
  // item is offered until a rising edge sees tready. At that edge the item reaches
  // the predictor.
  task automatic send_item(gwm_pkg::cmd_t cmd, logic [CW-1:0] code = '0,
                           logic last = 1'b0);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(gwm_pkg::IN_DATA_W-gwm_pkg::CMD_W-CW){1'b0}}, code, cmd};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    predict_transfer(cmd, code, last);
    transfers_sent++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Random back-pressure. A long hold is counted here once it has been requested.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict transfer with none expected: m_tdata=%h", m_tdata);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (m_tdata[0] !== want.matched) begin
          $error("matched: expected %0b, got %0b", want.matched, m_tdata[0]);
          fail_count++;
        end
        if (m_tdata[1] !== want.overflow) begin
          $error("pattern_overflow: expected %0b, got %0b", want.overflow, m_tdata[1]);
          fail_count++;
        end
      end
    end
  end

  // The watchdog fires when neither side has moved a transfer for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // An empty pattern matches the empty text and nothing else.
  task automatic test_empty_pattern();
    send_item(gwm_pkg::CMD_CLEAR);
    send_item(gwm_pkg::CMD_QUERY);
    send_item(gwm_pkg::CMD_TEXT, 16'h0061, 1'b1);
  endtask

  // Pattern "*?" followed by the highest code. The text "x", 0, FFFF matches it.
  // The empty text does not, as the question mark and the final code need characters.
  task automatic test_wildcards();
    send_item(gwm_pkg::CMD_APPEND, STAR);
    send_item(gwm_pkg::CMD_APPEND, QMARK);
    send_item(gwm_pkg::CMD_APPEND, 16'hFFFF);
    send_item(gwm_pkg::CMD_TEXT, 16'h0078);
    send_item(gwm_pkg::CMD_TEXT, 16'h0000);
    send_item(gwm_pkg::CMD_TEXT, 16'hFFFF, 1'b1);
    send_item(gwm_pkg::CMD_QUERY);
  endtask

  // A query in the middle of a text answers for the empty text. An append in the
  // middle of a text drops that text, so the next text character starts a new text.
  task automatic test_text_abandon();
    send_item(gwm_pkg::CMD_TEXT, 16'h0062);
    send_item(gwm_pkg::CMD_QUERY);
    send_item(gwm_pkg::CMD_TEXT, 16'h0063);
    send_item(gwm_pkg::CMD_APPEND, STAR);
    send_item(gwm_pkg::CMD_TEXT, 16'h0000);
    send_item(gwm_pkg::CMD_TEXT, 16'hFFFF, 1'b1);
  endtask

  // Once no position is live, the rest of the text is still read in. The answer is 0.
  task automatic test_dead_text();
    send_item(gwm_pkg::CMD_CLEAR);
    send_item(gwm_pkg::CMD_APPEND, 16'h0061);
    send_item(gwm_pkg::CMD_TEXT, 16'h0062);
    send_item(gwm_pkg::CMD_TEXT, 16'h0061, 1'b1);
  endtask

  // A full pattern of 31 stars and a 'z'. The chain of stars runs across every position
  // but the last. One more append overflows and forces 0. A clear removes the overflow.
  task automatic test_pattern_full();
    send_item(gwm_pkg::CMD_CLEAR);
    for (int i = 0; i < PAT_MAX - 1; i++) send_item(gwm_pkg::CMD_APPEND, STAR);
    send_item(gwm_pkg::CMD_APPEND, 16'h007A);
    send_item(gwm_pkg::CMD_TEXT, 16'h007A, 1'b1);
    send_item(gwm_pkg::CMD_APPEND, 16'h0079);
    send_item(gwm_pkg::CMD_TEXT, 16'h007A, 1'b1);
    send_item(gwm_pkg::CMD_CLEAR);
    send_item(gwm_pkg::CMD_QUERY);
  endtask

  // The output stalls for a long stretch while queries keep coming. The matcher
  // must fill up and hold its input, and it must not lose a verdict.
  task automatic test_output_backpressure();
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_item(gwm_pkg::CMD_QUERY);
  endtask

  // One random sequence: usually a clear, a pattern and a few texts. A few
  // sequences are noise. A few break a text with an append or a query.
  task automatic send_random_sequence();
    logic [CW-1:0]     alphabet [3];
    logic [CW-1:0]     c;
    int unsigned       plen;
    int unsigned       tlen;
    int unsigned       pick;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 4))
        send_item(gwm_pkg::cmd_t'($urandom_range(3)), CW'($urandom()), 1'($urandom()));
      return;
    end
    alphabet[0] = CW'($urandom_range(16'h61, 16'h63));
    alphabet[1] = CW'($urandom());
    pick = $urandom_range(3);
    alphabet[2] = (pick == 0) ? STAR : (pick == 1) ? QMARK : (pick == 2) ? 16'hFFFF : 16'h0000;
    // Most sequences start from an empty pattern. The rest extend the one loaded.
    if ($urandom_range(99) < 90) send_item(gwm_pkg::CMD_CLEAR);
    plen = ($urandom_range(99) < 5) ? $urandom_range(30, 36) : $urandom_range(0, 8);
    repeat (plen) begin
      pick = $urandom_range(99);
      if (pick < 30) c = STAR;
      else if (pick < 45) c = QMARK;
      else c = alphabet[$urandom_range(2)];
      send_item(gwm_pkg::CMD_APPEND, c);
    end
    repeat ($urandom_range(1, 4)) begin
      tlen = $urandom_range(0, 10);
      if (tlen == 0) begin
        send_item(gwm_pkg::CMD_QUERY);
      end else begin
        for (int i = 0; i < tlen; i++) begin
          if ($urandom_range(99) < 3)
            send_item(($urandom_range(1) != 0) ? gwm_pkg::CMD_APPEND : gwm_pkg::CMD_QUERY,
                      alphabet[$urandom_range(2)]);
          c = ($urandom_range(99) < 85) ? alphabet[$urandom_range(2)] : CW'($urandom());
          send_item(gwm_pkg::CMD_TEXT, c, i == tlen - 1);
        end
      end
    end
  endtask

  task automatic run_random_phase(int unsigned send_pct, int unsigned recv_pct,
                                  int unsigned sent_target);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (transfers_sent < sent_target) send_random_sequence();
  endtask

  initial begin
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tlast        = 1'b0;
    rst            = 1'b1;
    send_idle_pct  = 26;
    recv_idle_pct  = 63;
    hold_request   = 0;
    transfers_sent = 0;
    fail_count     = 0;
    stall_cycles   = 0;
    pat_len        = 0;
    live_set       = '0;
    in_text        = 1'b0;
    pat_overflow   = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_pattern();
    test_wildcards();
    test_text_abandon();
    test_dead_text();
    test_pattern_full();
    run_random_phase(26, 63, 650);
    run_random_phase(63, 26, 1300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    run_random_phase(0, 0, 1950);

    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/gwm_pkg.sv
hw/rtl/glob_wildcard_matcher_unit.sv
hw/rtl/gwm_checker.sv
tb/testbench.sv
